@@ design/particle_pool_engine_macros.svh @@
// Assertion macros used by the particle pool engine top level.
`ifndef PARTICLE_POOL_ENGINE_MACROS_SVH
`define PARTICLE_POOL_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define PPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("particle pool engine: same-cycle check failed");
`define PPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("particle pool engine: next-cycle check failed");
`else
`define PPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/ppe_pkg.sv @@
// Types and constants shared by the particle pool engine modules.
`default_nettype none
package ppe_pkg;

    localparam int POS_W      = 32;
    localparam int DT_W       = 16;
    localparam int LIFE_W     = 16;
    localparam int COLOR_W    = 24;
    localparam int SIZE_W     = 32;
    localparam int DECAY_W    = 24;
    localparam int OP_W       = 2;
    localparam int PROD_W     = POS_W + DT_W + 1;
    localparam int LOSS_W     = 24;
    localparam int LOSS_SHIFT = 17;
    localparam int LOSS_SUM_W = DECAY_W + DT_W + 1;

    localparam logic [OP_W-1:0]       OP_ADD      = 2'd0;
    localparam logic [OP_W-1:0]       OP_TICK     = 2'd1;
    localparam logic [OP_W-1:0]       OP_DRAW     = 2'd2;
    localparam logic [LIFE_W-1:0]     LIFE_FULL   = 16'h8000;
    localparam logic [DECAY_W-1:0]    DECAY_RESET = 24'h01_0000;
    localparam logic [LOSS_SUM_W-1:0] LOSS_ROUND  = LOSS_SUM_W'(17'h1_FFFF);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_FIND   = 10'b00_0000_0010,
        S_LOSS0  = 10'b00_0000_0100,
        S_LOSS1  = 10'b00_0000_1000,
        S_TREAD  = 10'b00_0001_0000,
        S_TMULX  = 10'b00_0010_0000,
        S_TMULY  = 10'b00_0100_0000,
        S_TWRY   = 10'b00_1000_0000,
        S_DSCAN  = 10'b01_0000_0000,
        S_DFLUSH = 10'b10_0000_0000
    } t_state;

    // Read and write strobes for the slot stores.
    typedef struct packed {
        logic rd;
        logic add;
        logic posx;
        logic posy;
        logic life;
    } t_store_we;

endpackage
`default_nettype wire

@@ design/particle_pool_engine.sv @@
// Top level of the particle pool engine: sequencer, live flags and result registers.
//
// Commands are taken at a rising edge with start high and busy low; busy stays
// high until the command has finished. Op add searches for a dead slot, one
// slot per cycle, from the last slot taken and wrapping round; slot 0 is
// overwritten when the pool is full. Op tick first forms the life loss in
// S_LOSS0 and S_LOSS1, then visits each slot; a live slot passes through
// S_TREAD, S_TMULX, S_TMULY and S_TWRY, as both axes pass through the one
// shared multiplier. Op draw walks the pool at one slot per cycle.
// Each result appears on the result ports for one cycle with o_strobe high,
// in ascending slot order, the final one with o_last high; a result lags its
// slot by one live slot, as the run end is only known after the pool is read.
// A draw over an empty pool gives a single result with o_valid_res low.
// The receiver cannot stall, so results are never held back. The decay register
// is written through i_cfg_we and i_cfg_wdata; the user must write it only while
// idle, as the block does not enforce it. Reset clears every live flag at once,
// sets decay to 1.0 per second, search start to slot 0; memories need no clearing.
`default_nettype none
`include "particle_pool_engine_macros.svh"
module particle_pool_engine
    import ppe_pkg::*;
#(
    parameter int POOL_SIZE = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic        [OP_W-1:0]   i_op,
    input  wire logic signed [POS_W-1:0]  i_pos_x,
    input  wire logic signed [POS_W-1:0]  i_pos_y,
    input  wire logic signed [POS_W-1:0]  i_vel_x,
    input  wire logic signed [POS_W-1:0]  i_vel_y,
    input  wire logic        [COLOR_W-1:0] i_color,
    input  wire logic        [SIZE_W-1:0] i_size,
    input  wire logic        [DT_W-1:0]   i_delta_time,
    input  wire logic                     i_cfg_we,
    input  wire logic        [DECAY_W-1:0] i_cfg_wdata,
    output logic                          o_strobe,
    output logic                          o_valid_res,
    output logic                          o_last,
    output logic signed      [POS_W-1:0]  o_out_x,
    output logic signed      [POS_W-1:0]  o_out_y,
    output logic             [SIZE_W-1:0] o_out_size,
    output logic             [COLOR_W-1:0] o_out_color
);

    localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

    t_state r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_cnt, n_cnt;
    logic [IDX_W-1:0]     r_search, n_search;
    logic [POOL_SIZE-1:0] r_live, n_live;
    logic                 r_have, n_have;
    logic                 r_strobe, n_strobe;
    logic [DECAY_W-1:0]   r_decay;

    logic [POS_W-1:0]   r_in_posx, r_in_posy, r_in_velx, r_in_vely;
    logic [COLOR_W-1:0] r_in_color;
    logic [SIZE_W-1:0]  r_in_size;
    logic [DT_W-1:0]    r_dt;
    logic [LOSS_W-1:0]  r_loss;

    t_store_we          st_ctl;
    logic [IDX_W-1:0]   st_addr;
    logic               load_in;
    logic               emit_pend;
    logic               emit_last;
    logic               search_ok;

    logic [POS_W-1:0]   q_posx, q_posy, q_velx, q_vely;
    logic [COLOR_W-1:0] q_color;
    logic [SIZE_W-1:0]  q_size;
    logic [LIFE_W-1:0]  q_life;
    logic [LIFE_W-1:0]  new_life;
    logic [LOSS_SUM_W-1:0] loss_sum;

    logic signed [POS_W-1:0]  ar_vel, ar_pos;
    logic signed [PROD_W-1:0] ar_prod;
    logic signed [POS_W-1:0]  ar_sum;

    assign busy      = (r_state != S_IDLE);
    assign search_ok = ({1'b0, r_search} < (IDX_W+1)'(POOL_SIZE));

    assign new_life = (r_loss >= LOSS_W'(q_life)) ? '0 : (q_life - r_loss[LIFE_W-1:0]);
    assign loss_sum = {1'b0, ar_prod[LOSS_SUM_W-2:0]} + LOSS_ROUND;

    always_comb begin
        unique case (r_state)
            S_LOSS0: begin
                ar_vel = $signed({{(POS_W-DECAY_W){1'b0}}, r_decay});
                ar_pos = '0;
            end
            S_TMULY: begin
                ar_vel = $signed(q_vely);
                ar_pos = $signed(q_posy);
            end
            default: begin
                ar_vel = $signed(q_velx);
                ar_pos = $signed(q_posx);
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_search  = r_search;
        n_live    = r_live;
        n_have    = r_have;
        n_strobe  = 1'b0;
        st_ctl    = '0;
        st_addr   = r_idx;
        load_in   = 1'b0;
        emit_pend = 1'b0;
        emit_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    load_in = 1'b1;
                    case (i_op)
                        OP_ADD: begin
                            n_state = S_FIND;
                            n_idx   = search_ok ? r_search : '0;
                            n_cnt   = '0;
                        end
                        OP_TICK: begin
                            n_state = S_LOSS0;
                            n_idx   = '0;
                        end
                        OP_DRAW: begin
                            n_state = S_DSCAN;
                            n_idx   = '0;
                            n_have  = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (!r_live[r_idx] || (r_cnt == LAST_IDX)) begin
                    // With no dead slot left, slot 0 is overwritten.
                    if (r_live[r_idx]) begin
                        st_addr = '0;
                    end else begin
                        n_search = r_idx;
                    end
                    st_ctl.add  = 1'b1;
                    st_ctl.posx = 1'b1;
                    st_ctl.posy = 1'b1;
                    st_ctl.life = 1'b1;
                    n_live[st_addr] = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = (r_idx == LAST_IDX) ? '0 : (r_idx + IDX_W'(1));
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
            S_LOSS0: begin
                n_state = S_LOSS1;
            end
            S_LOSS1: begin
                n_state = S_TREAD;
            end
            S_TREAD: begin
                if (r_live[r_idx]) begin
                    st_ctl.rd = 1'b1;
                    n_state   = S_TMULX;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_TMULX: begin
                st_ctl.life   = 1'b1;
                n_live[r_idx] = (new_life != '0);
                n_state       = S_TMULY;
            end
            S_TMULY: begin
                st_ctl.posx = 1'b1;
                n_state     = S_TWRY;
            end
            S_TWRY: begin
                st_ctl.posy = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_TREAD;
                end
            end
            S_DSCAN: begin
                // The previous live slot is reported once a later one is found.
                if (r_live[r_idx]) begin
                    st_ctl.rd = 1'b1;
                    n_have    = 1'b1;
                    if (r_have) begin
                        n_strobe  = 1'b1;
                        emit_pend = 1'b1;
                    end
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_DFLUSH;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DFLUSH: begin
                n_strobe  = 1'b1;
                emit_last = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_search <= '0;
            r_live   <= '0;
            r_have   <= 1'b0;
            r_strobe <= 1'b0;
            r_decay  <= DECAY_RESET;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_search <= n_search;
            r_live   <= n_live;
            r_have   <= n_have;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_decay <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in_posx  <= i_pos_x;
            r_in_posy  <= i_pos_y;
            r_in_velx  <= i_vel_x;
            r_in_vely  <= i_vel_y;
            r_in_color <= i_color;
            r_in_size  <= i_size;
            r_dt       <= i_delta_time;
        end
        if (r_state == S_LOSS1) begin
            r_loss <= loss_sum[LOSS_SHIFT +: LOSS_W];
        end
        if (emit_pend) begin
            o_valid_res <= 1'b1;
            o_last      <= 1'b0;
            o_out_x     <= q_posx;
            o_out_y     <= q_posy;
            o_out_size  <= q_size;
            o_out_color <= q_color;
        end else if (emit_last) begin
            o_valid_res <= r_have;
            o_last      <= 1'b1;
            o_out_x     <= r_have ? q_posx  : '0;
            o_out_y     <= r_have ? q_posy  : '0;
            o_out_size  <= r_have ? q_size  : '0;
            o_out_color <= r_have ? q_color : '0;
        end
    end

    assign o_strobe = r_strobe;

    ppe_arith u_arith (
        .i_clk  (i_clk),
        .i_vel  (ar_vel),
        .i_pos  (ar_pos),
        .i_dt   (r_dt),
        .o_prod (ar_prod),
        .o_sum  (ar_sum)
    );

    ppe_store #(
        .POOL_SIZE (POOL_SIZE),
        .IDX_W     (IDX_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_ctl      (st_ctl),
        .i_addr     (st_addr),
        .i_posx_wd  ((r_state == S_FIND) ? r_in_posx : ar_sum),
        .i_posy_wd  ((r_state == S_FIND) ? r_in_posy : ar_sum),
        .i_velx_wd  (r_in_velx),
        .i_vely_wd  (r_in_vely),
        .i_color_wd (r_in_color),
        .i_size_wd  (r_in_size),
        .i_life_wd  ((r_state == S_FIND) ? LIFE_FULL : new_life),
        .o_posx_q   (q_posx),
        .o_posy_q   (q_posy),
        .o_velx_q   (q_velx),
        .o_vely_q   (q_vely),
        .o_color_q  (q_color),
        .o_size_q   (q_size),
        .o_life_q   (q_life)
    );

    // An empty draw gives one transaction, and it is always the final one.
    `PPE_ASSERT_SAME(a_empty_is_last, i_clk, i_rst_n, o_strobe && !o_valid_res, o_last)
    // Results only come out of a command that was still running in the previous cycle.
    `PPE_ASSERT_SAME(a_res_from_busy, i_clk, i_rst_n, o_strobe, $past(busy))
    // The final result of a draw is never followed at once by another one.
    `PPE_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, o_strobe && o_last, !o_strobe)

endmodule
`default_nettype wire

@@ design/ppe_arith.sv @@
// Shared multiply, floor shift, add and saturate unit for particle motion and the life loss.
`default_nettype none
module ppe_arith
    import ppe_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic signed [POS_W-1:0]  i_vel,
    input  wire logic signed [POS_W-1:0]  i_pos,
    input  wire logic        [DT_W-1:0]   i_dt,
    output logic signed      [PROD_W-1:0] o_prod,
    output logic signed      [POS_W-1:0]  o_sum
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [POS_W-1:0]  r_pos;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [POS_W:0]    n_step;
    logic signed [POS_W+1:0]  n_full;

    assign n_prod = PROD_W'(i_vel) * PROD_W'($signed({1'b0, i_dt}));

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_pos  <= i_pos;
    end

    // An arithmetic shift of the product rounds towards minus infinity.
    assign n_step = r_prod[PROD_W-1:DT_W];
    assign n_full = (POS_W+2)'(r_pos) + (POS_W+2)'(n_step);

    always_comb begin
        if (!n_full[POS_W+1] && (n_full[POS_W:POS_W-1] != 2'b00)) begin
            o_sum = {1'b0, {(POS_W-1){1'b1}}};
        end else if (n_full[POS_W+1] && (n_full[POS_W:POS_W-1] != 2'b11)) begin
            o_sum = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            o_sum = n_full[POS_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

@@ design/ppe_store.sv @@
// Per-slot particle memories with registered read data.
`default_nettype none
module ppe_store
    import ppe_pkg::*;
#(
    parameter int POOL_SIZE = 64,
    parameter int IDX_W     = 6
) (
    input  wire logic                 i_clk,
    input  wire t_store_we            i_ctl,
    input  wire logic [IDX_W-1:0]     i_addr,
    input  wire logic [POS_W-1:0]     i_posx_wd,
    input  wire logic [POS_W-1:0]     i_posy_wd,
    input  wire logic [POS_W-1:0]     i_velx_wd,
    input  wire logic [POS_W-1:0]     i_vely_wd,
    input  wire logic [COLOR_W-1:0]   i_color_wd,
    input  wire logic [SIZE_W-1:0]    i_size_wd,
    input  wire logic [LIFE_W-1:0]    i_life_wd,
    output logic      [POS_W-1:0]     o_posx_q,
    output logic      [POS_W-1:0]     o_posy_q,
    output logic      [POS_W-1:0]     o_velx_q,
    output logic      [POS_W-1:0]     o_vely_q,
    output logic      [COLOR_W-1:0]   o_color_q,
    output logic      [SIZE_W-1:0]    o_size_q,
    output logic      [LIFE_W-1:0]    o_life_q
);

    logic [POS_W-1:0]   r_posx_mem  [POOL_SIZE];
    logic [POS_W-1:0]   r_posy_mem  [POOL_SIZE];
    logic [POS_W-1:0]   r_velx_mem  [POOL_SIZE];
    logic [POS_W-1:0]   r_vely_mem  [POOL_SIZE];
    logic [COLOR_W-1:0] r_color_mem [POOL_SIZE];
    logic [SIZE_W-1:0]  r_size_mem  [POOL_SIZE];
    logic [LIFE_W-1:0]  r_life_mem  [POOL_SIZE];

    always_ff @(posedge i_clk) begin
        if (i_ctl.posx) begin
            r_posx_mem[i_addr] <= i_posx_wd;
        end
        if (i_ctl.posy) begin
            r_posy_mem[i_addr] <= i_posy_wd;
        end
        if (i_ctl.add) begin
            r_velx_mem[i_addr]  <= i_velx_wd;
            r_vely_mem[i_addr]  <= i_vely_wd;
            r_color_mem[i_addr] <= i_color_wd;
            r_size_mem[i_addr]  <= i_size_wd;
        end
        if (i_ctl.life) begin
            r_life_mem[i_addr] <= i_life_wd;
        end
    end

    // Read data holds between reads, so a slot's values stay put while it is processed.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            o_posx_q  <= r_posx_mem[i_addr];
            o_posy_q  <= r_posy_mem[i_addr];
            o_velx_q  <= r_velx_mem[i_addr];
            o_vely_q  <= r_vely_mem[i_addr];
            o_color_q <= r_color_mem[i_addr];
            o_size_q  <= r_size_mem[i_addr];
            o_life_q  <= r_life_mem[i_addr];
        end
    end

endmodule
`default_nettype wire
